>>> design/dual_supply_voltage_monitor_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the supply monitor core
// Shared property forms; each expands to one labeled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef DUAL_SUPPLY_VOLTAGE_MONITOR_CORE_ASSERT_SVH
`define DUAL_SUPPLY_VOLTAGE_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define DSVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define DSVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define DSVM_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dsvm_pkg.sv
// ---------------------------------------------------------------------------
// dsvm_pkg
// Types, codes and reset values shared by the supply monitor files.
// ---------------------------------------------------------------------------
package dsvm_pkg;

  localparam int VOLT_BITS_DEF = 16;

  // register reset values, mV
  localparam int DC_OFF_RESET     = 2000;
  localparam int DC_ON_RESET      = 4000;
  localparam int USB_OFF_RESET    = 500;
  localparam int USB_ON_RESET     = 4000;
  localparam int EDGE_DELTA_RESET = 1000;
  localparam int LEVEL_RESET      = 1000;

  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_DC_OFF     = 3'd0,
    CFG_DC_ON      = 3'd1,
    CFG_USB_OFF    = 3'd2,
    CFG_USB_ON     = 3'd3,
    CFG_EDGE_DELTA = 3'd4,
    CFG_LEVEL      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ARM_DC  = 2'd1,
    OP_ARM_USB = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FALL = 2'd1,
    DIR_RISE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    EVT_NONE       = 2'd0,
    EVT_CONNECT    = 2'd1,
    EVT_DISCONNECT = 2'd2
  } usb_evt_t;

  typedef enum logic [1:0] {
    TRIG_NONE = 2'd0,
    TRIG_DC   = 2'd1,
    TRIG_USB  = 2'd2
  } trig_t;

  // result beat layout
  localparam int OUT_TDATA_BITS = 8;
  localparam int OUT_DC_BIT     = 0;
  localparam int OUT_USB_BIT    = 1;
  localparam int OUT_EVT_LSB    = 2;
  localparam int OUT_TRIG_LSB   = 4;
  localparam int OUT_POLL_BIT   = 6;

endpackage

>>> design/dual_supply_voltage_monitor_core.sv
// ---------------------------------------------------------------------------
// dual_supply_voltage_monitor_core
// Hysteresis presence flags, USB plug events and armed edge triggers for a
// DC input and USB VBUS supply pair.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one beat per command. Opcode 0 is a sample tick
//   carrying both voltages in mV; opcodes 1/2 arm or disarm the DC/USB
//   channel with a wanted edge polarity. Opcode 3 is a no-op.
//   Result stream (out_*): exactly one beat per input beat, in order,
//   carrying presence flags, USB event, trigger and polling status.
//   Config port (cfg_*): write-only thresholds, taken on any clk edge with
//   cfg_wen high; write only while the block is idle.
// Timing:
//   Beat lands in an input register, the whole decision is one level of
//   compares/subtracts, and the result is written to an output register.
//   out_tvalid rises once the beat moves from the input register into the
//   output register; one beat per cycle sustained while out_tready is high.
//   State (flags, last samples, arm bits) updates as an item leaves the
//   input register, so back-to-back ticks see each other's state.
// Reset: rst_n low (sync) clears flags, samples, arm state, both valids,
//   and loads the default thresholds.
// Stall: with out_tready low the output register holds; the input register
//   still takes one more beat, then in_tready drops until the result moves.
// ---------------------------------------------------------------------------
module dual_supply_voltage_monitor_core #(
  parameter int VOLT_BITS = dsvm_pkg::VOLT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // cfg port
  input  logic                                    cfg_wen,
  input  logic [dsvm_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [VOLT_BITS-1:0]                    cfg_wdata,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // low->high: opcode[1:0], dc_mv, usb_mv, arm_enable, arm_rising, zero pad
  input  logic [((2*VOLT_BITS+4+7)/8)*8-1:0]      in_tdata,
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // low->high: dc_present, usb_present, usb_event[1:0], trigger[1:0],
  //            polling_active, zero pad
  output logic [dsvm_pkg::OUT_TDATA_BITS-1:0]     out_tdata
);
  import dsvm_pkg::*;

  typedef logic [VOLT_BITS-1:0] volt_t;

  localparam int DC_LSB  = 2;
  localparam int USB_LSB = DC_LSB + VOLT_BITS;
  localparam int EN_BIT  = USB_LSB + VOLT_BITS;
  localparam int RISE_BIT = EN_BIT + 1;

  // edge direction from previous to current sample
  function automatic dir_t edge_dir(volt_t prev, volt_t cur, volt_t delta);
    logic [VOLT_BITS:0] up;
    logic [VOLT_BITS:0] dn;
    dir_t               d;
    up = {1'b0, cur} - {1'b0, prev};
    dn = {1'b0, prev} - {1'b0, cur};
    d  = DIR_NONE;
    if (!up[VOLT_BITS] && (up[VOLT_BITS-1:0] > delta)) begin
      d = DIR_RISE;
    end else if (!dn[VOLT_BITS] && (dn[VOLT_BITS-1:0] > delta)) begin
      d = DIR_FALL;
    end
    return d;
  endfunction

  // config registers
  volt_t dc_off_r, dc_on_r, usb_off_r, usb_on_r, delta_r, level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_off_r  <= volt_t'(DC_OFF_RESET);
      dc_on_r   <= volt_t'(DC_ON_RESET);
      usb_off_r <= volt_t'(USB_OFF_RESET);
      usb_on_r  <= volt_t'(USB_ON_RESET);
      delta_r   <= volt_t'(EDGE_DELTA_RESET);
      level_r   <= volt_t'(LEVEL_RESET);
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_DC_OFF:     dc_off_r  <= cfg_wdata;
        CFG_DC_ON:      dc_on_r   <= cfg_wdata;
        CFG_USB_OFF:    usb_off_r <= cfg_wdata;
        CFG_USB_ON:     usb_on_r  <= cfg_wdata;
        CFG_EDGE_DELTA: delta_r   <= cfg_wdata;
        CFG_LEVEL:      level_r   <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // input register stage
  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  volt_t      s1_dc_r, s1_usb_r;
  logic       s1_en_r, s1_rise_r;
  logic       s1_go;
  logic       out_valid_r;
  logic [OUT_TDATA_BITS-1:0] out_data_r, out_data_nxt;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tdata[1:0];
      s1_dc_r   <= in_tdata[USB_LSB-1:DC_LSB];
      s1_usb_r  <= in_tdata[EN_BIT-1:USB_LSB];
      s1_en_r   <= in_tdata[EN_BIT];
      s1_rise_r <= in_tdata[RISE_BIT];
    end
  end

  // monitor state
  logic       dc_flag_r, usb_flag_r, restart_r;
  volt_t      dc_last_r, usb_last_r;
  logic [1:0] arm_r, pol_r;

  logic       dc_flag_nxt, usb_flag_nxt, restart_nxt;
  volt_t      dc_last_nxt, usb_last_nxt;
  logic [1:0] arm_nxt, pol_nxt;
  usb_evt_t   evt;
  trig_t      trig;
  dir_t       dc_dir, usb_dir;
  dir_t       dc_want, usb_want;

  always_comb begin
    dc_flag_nxt  = dc_flag_r;
    usb_flag_nxt = usb_flag_r;
    restart_nxt  = restart_r;
    dc_last_nxt  = dc_last_r;
    usb_last_nxt = usb_last_r;
    arm_nxt      = arm_r;
    pol_nxt      = pol_r;
    evt          = EVT_NONE;
    trig         = TRIG_NONE;
    dc_want      = pol_r[0] ? DIR_RISE : DIR_FALL;
    usb_want     = pol_r[1] ? DIR_RISE : DIR_FALL;

    // first tick after arming judges against the configured level
    if (restart_r) begin
      dc_dir  = (s1_dc_r > level_r) ? DIR_RISE : DIR_FALL;
      usb_dir = (s1_usb_r > level_r) ? DIR_RISE : DIR_FALL;
    end else begin
      dc_dir  = edge_dir(dc_last_r, s1_dc_r, delta_r);
      usb_dir = edge_dir(usb_last_r, s1_usb_r, delta_r);
    end

    unique case (s1_op_r)
      OP_TICK: begin
        if (dc_flag_r && (s1_dc_r <= dc_off_r)) begin
          dc_flag_nxt = 1'b0;
        end else if (!dc_flag_r && (s1_dc_r >= dc_on_r)) begin
          dc_flag_nxt = 1'b1;
        end

        // USB event uses the freshly updated DC flag
        if (usb_flag_r && (s1_usb_r <= usb_off_r)) begin
          usb_flag_nxt = 1'b0;
          if (dc_flag_nxt) evt = EVT_DISCONNECT;
        end else if (!usb_flag_r && (s1_usb_r >= usb_on_r)) begin
          usb_flag_nxt = 1'b1;
          if (dc_flag_nxt) evt = EVT_CONNECT;
        end

        restart_nxt  = 1'b0;
        dc_last_nxt  = s1_dc_r;
        usb_last_nxt = s1_usb_r;

        priority if (arm_r[0] && (dc_dir == dc_want)) begin
          trig = TRIG_DC;
        end else if (arm_r[1] && (usb_dir == usb_want)) begin
          trig = TRIG_USB;
        end else if ((s1_dc_r == '0) && (s1_usb_r == '0)) begin
          arm_nxt = 2'b00;  // both rails dead: stop polling
        end
      end
      OP_ARM_DC: begin
        restart_nxt = 1'b1;
        arm_nxt[0]  = s1_en_r;
        pol_nxt[0]  = s1_rise_r;
      end
      OP_ARM_USB: begin
        restart_nxt = 1'b1;
        arm_nxt[1]  = s1_en_r;
        pol_nxt[1]  = s1_rise_r;
      end
      default: ;  // spare opcode, no state change
    endcase

    out_data_nxt = '0;
    out_data_nxt[OUT_DC_BIT]                  = dc_flag_nxt;
    out_data_nxt[OUT_USB_BIT]                 = usb_flag_nxt;
    out_data_nxt[OUT_EVT_LSB+1:OUT_EVT_LSB]   = evt;
    out_data_nxt[OUT_TRIG_LSB+1:OUT_TRIG_LSB] = trig;
    out_data_nxt[OUT_POLL_BIT]                = |arm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_flag_r  <= 1'b0;
      usb_flag_r <= 1'b0;
      restart_r  <= 1'b0;
      dc_last_r  <= '0;
      usb_last_r <= '0;
      arm_r      <= 2'b00;
      pol_r      <= 2'b00;
    end else if (s1_go) begin
      dc_flag_r  <= dc_flag_nxt;
      usb_flag_r <= usb_flag_nxt;
      restart_r  <= restart_nxt;
      dc_last_r  <= dc_last_nxt;
      usb_last_r <= usb_last_nxt;
      arm_r      <= arm_nxt;
      pol_r      <= pol_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/dsvm_checker.sv
// ---------------------------------------------------------------------------
// dsvm_checker
// Port-level checks on the supply monitor result stream.
// ---------------------------------------------------------------------------
`include "dual_supply_voltage_monitor_core_assert.svh"

module dsvm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [dsvm_pkg::OUT_TDATA_BITS-1:0] out_tdata
);
  import dsvm_pkg::*;

  logic       dc_p, usb_p, poll;
  logic [1:0] evt, trig;

  assign dc_p = out_tdata[OUT_DC_BIT];
  assign usb_p = out_tdata[OUT_USB_BIT];
  assign evt  = out_tdata[OUT_EVT_LSB+1:OUT_EVT_LSB];
  assign trig = out_tdata[OUT_TRIG_LSB+1:OUT_TRIG_LSB];
  assign poll = out_tdata[OUT_POLL_BIT];

  // stalled result beat must hold
  `DSVM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // connect means both rails now present
  `DSVM_ASSERT_NOW(a_connect_flags, out_tvalid && (evt == EVT_CONNECT),
    dc_p && usb_p, "USB connect without DC and USB present")

  // disconnect means USB gone while DC stays
  `DSVM_ASSERT_NOW(a_disconnect_flags, out_tvalid && (evt == EVT_DISCONNECT),
    dc_p && !usb_p, "USB disconnect with wrong presence flags")

  // a trigger never disarms, so polling stays on
  `DSVM_ASSERT_NOW(a_trig_polling, out_tvalid && (trig != TRIG_NONE),
    poll, "trigger raised with polling inactive")

  // no result right out of reset
  `DSVM_ASSERT_ALWAYS_NEXT(a_reset_quiet, !rst_n, !out_tvalid,
    "result valid after reset")

endmodule

bind dual_supply_voltage_monitor_core dsvm_checker u_dsvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb_dual_supply_voltage_monitor_core.sv
// ---------------------------------------------------------------------------
// Supply monitor core regression bench
// Drives commands into dual_supply_voltage_monitor_core over the input
// stream and checks each result beat against a local model of the hysteresis
// flags, USB plug events, edge triggers and arm state. A directed table runs
// first, then random phases under several threshold settings, with random
// idle bursts on both streams except in the last phase.
// ---------------------------------------------------------------------------
module tb_dual_supply_voltage_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dsvm_pkg::*;

  localparam int VB       = VOLT_BITS_DEF;
  localparam int IN_W     = ((2*VB+4+7)/8)*8;
  localparam int MV_MAX   = (1 << VB) - 1;
  // in_tdata bit positions, low to high
  localparam int DC_LSB   = 2;
  localparam int USB_LSB  = 2 + VB;
  localparam int EN_BIT   = 2 + 2*VB;
  localparam int RISE_BIT = 3 + 2*VB;

  localparam logic [1:0] OP_SPARE = 2'd3;  // opcode with no function
  // indexes past the register file, writes must be dropped
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_B = 3'd7;

  localparam int CH_DC  = 0;
  localparam int CH_USB = 1;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam cfg_idx_t REG_ORDER [6] = '{CFG_DC_OFF, CFG_DC_ON, CFG_USB_OFF,
                                         CFG_USB_ON, CFG_EDGE_DELTA, CFG_LEVEL};

  typedef struct packed {
    logic [1:0]    opcode;
    logic [VB-1:0] dc_mv;
    logic [VB-1:0] usb_mv;
    logic          arm_enable;
    logic          arm_rising;
  } cmd_t;

  typedef struct packed {
    logic     dc_present;
    logic     usb_present;
    usb_evt_t usb_event;
    trig_t    trigger;
    logic     polling_active;
  } status_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;   // 1: use the hand-written result below
    status_t want;
  } dir_row_t;

  localparam status_t NO_STATUS = '{1'b0, 1'b0, EVT_NONE, TRIG_NONE, 1'b0};

  // Directed table. Defaults are in force: DC 2000/4000, USB 500/4000,
  // delta 1000, level 1000. Rows with typed=0 go through the model.
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // quiet tick out of reset: everything stays low
    '{'{OP_TICK,    16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, EVT_NONE, TRIG_NONE, 1'b0}},
    // unused opcode with every field bit set: no effect
    '{'{OP_SPARE,   16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
      '{1'b0, 1'b0, EVT_NONE, TRIG_NONE, 1'b0}},
    // both supplies at full scale: DC sets first, so USB reports connect
    '{'{OP_TICK,    16'hFFFF, 16'hFFFF, 1'b0, 1'b0}, 1'b1,
      '{1'b1, 1'b1, EVT_CONNECT, TRIG_NONE, 1'b0}},
    // USB drops to zero with DC held: disconnect; arm bits ignored on ticks
    '{'{OP_TICK,    16'hFFFF, 16'h0000, 1'b1, 1'b1}, 1'b1,
      '{1'b1, 1'b0, EVT_DISCONNECT, TRIG_NONE, 1'b0}},
    // arm DC falling: flags carried, polling on
    '{'{OP_ARM_DC,  16'h0000, 16'h0000, 1'b1, 1'b0}, 1'b1,
      '{1'b1, 1'b0, EVT_NONE, TRIG_NONE, 1'b1}},
    // first tick after arm: below level reads as falling
    '{'{OP_TICK,    16'd500,  16'd0,    1'b0, 1'b0}, 1'b0, NO_STATUS},
    // arm USB rising, voltage fields ignored
    '{'{OP_ARM_USB, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_STATUS},
    // both channels match: DC wins
    '{'{OP_TICK,    16'd0,    16'd5000, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_ARM_DC,  16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    // no match and both zero: everything disarms
    '{'{OP_TICK,    16'd0,    16'd0,    1'b0, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_ARM_USB, 16'h0000, 16'h0000, 1'b1, 1'b1}, 1'b0, NO_STATUS},
    '{'{OP_TICK,    16'd0,    16'd2000, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_TICK,    16'd0,    16'd2000, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    // change exactly equal to delta is not an edge
    '{'{OP_TICK,    16'd0,    16'd3000, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    // one past delta: edge; USB sets without DC, so no event
    '{'{OP_TICK,    16'd0,    16'd4001, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_ARM_USB, 16'h0000, 16'h0000, 1'b1, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_TICK,    16'd0,    16'd4001, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    // falling edge triggers; trigger keeps the arm state even at zero
    '{'{OP_TICK,    16'd0,    16'd0,    1'b0, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_ARM_DC,  16'h0000, 16'h0000, 1'b1, 1'b1}, 1'b0, NO_STATUS},
    // sample equal to level counts as falling
    '{'{OP_TICK,    16'd1000, 16'd0,    1'b0, 1'b0}, 1'b0, NO_STATUS},
    '{'{OP_TICK,    16'd0,    16'd0,    1'b0, 1'b0}, 1'b0, NO_STATUS},
    // exactly on the set thresholds
    '{'{OP_TICK,    16'd4000, 16'd4000, 1'b0, 1'b0}, 1'b0, NO_STATUS},
    // exactly on the clear thresholds: DC clears first, no disconnect
    '{'{OP_TICK,    16'd2000, 16'd500,  1'b0, 1'b0}, 1'b0, NO_STATUS}
  };

  // DUT signals; the driven inputs are known from time zero
  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_wen    = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr   = '0;
  logic [VB-1:0]            cfg_wdata  = '0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;

  // Model copy of the register file
  logic [VB-1:0] th_dc_off  = VB'(DC_OFF_RESET);
  logic [VB-1:0] th_dc_on   = VB'(DC_ON_RESET);
  logic [VB-1:0] th_usb_off = VB'(USB_OFF_RESET);
  logic [VB-1:0] th_usb_on  = VB'(USB_ON_RESET);
  logic [VB-1:0] th_delta   = VB'(EDGE_DELTA_RESET);
  logic [VB-1:0] th_level   = VB'(LEVEL_RESET);

  // Model state
  logic          dc_seen         = 1'b0;
  logic          usb_seen        = 1'b0;
  logic [VB-1:0] prev_dc         = '0;
  logic [VB-1:0] prev_usb        = '0;
  logic          first_after_arm = 1'b0;
  logic [1:0]    armed           = '0;
  logic [1:0]    want_rise       = '0;

  status_t pending_status [$];   // results still owed by the DUT, oldest first
  int      mismatches  = 0;
  int      idle_cycles = 0;
  int      stall_left  = 0;
  bit      calm_tail   = 1'b0;   // no idle bursts on either side

  dual_supply_voltage_monitor_core #(.VOLT_BITS(VB)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Direction between consecutive samples; the change has to beat delta.
  function automatic dir_t slope(input logic [VB-1:0] prev, input logic [VB-1:0] cur);
    if (cur > prev && (cur - prev) > th_delta) return DIR_RISE;
    if (prev > cur && (prev - cur) > th_delta) return DIR_FALL;
    return DIR_NONE;
  endfunction

  // Advances the model by one command and returns the beat it should cause.
  function automatic status_t predict_status(input cmd_t c);
    status_t s;
    dir_t    dc_dir;
    dir_t    usb_dir;
    int      ch;
    s.usb_event = EVT_NONE;
    s.trigger   = TRIG_NONE;
    if (c.opcode == OP_TICK) begin
      // set and clear tests are gated on the current flag, so overlapping
      // thresholds still resolve one way
      if (dc_seen && c.dc_mv <= th_dc_off) dc_seen = 1'b0;
      else if (!dc_seen && c.dc_mv >= th_dc_on) dc_seen = 1'b1;
      // event uses the DC flag as just updated
      if (usb_seen && c.usb_mv <= th_usb_off) begin
        usb_seen = 1'b0;
        if (dc_seen) s.usb_event = EVT_DISCONNECT;
      end else if (!usb_seen && c.usb_mv >= th_usb_on) begin
        usb_seen = 1'b1;
        if (dc_seen) s.usb_event = EVT_CONNECT;
      end
      if (first_after_arm) begin
        first_after_arm = 1'b0;
        dc_dir  = (c.dc_mv  > th_level) ? DIR_RISE : DIR_FALL;
        usb_dir = (c.usb_mv > th_level) ? DIR_RISE : DIR_FALL;
      end else begin
        dc_dir  = slope(prev_dc, c.dc_mv);
        usb_dir = slope(prev_usb, c.usb_mv);
      end
      prev_dc  = c.dc_mv;
      prev_usb = c.usb_mv;
      if (armed[CH_DC] && dc_dir == (want_rise[CH_DC] ? DIR_RISE : DIR_FALL))
        s.trigger = TRIG_DC;
      else if (armed[CH_USB] && usb_dir == (want_rise[CH_USB] ? DIR_RISE : DIR_FALL))
        s.trigger = TRIG_USB;
      else if (c.dc_mv == '0 && c.usb_mv == '0)
        armed = '0;
    end else if (c.opcode == OP_ARM_DC || c.opcode == OP_ARM_USB) begin
      ch = (c.opcode == OP_ARM_DC) ? CH_DC : CH_USB;
      armed[ch]       = c.arm_enable;
      want_rise[ch]   = c.arm_rising;
      first_after_arm = 1'b1;
    end
    s.dc_present     = dc_seen;
    s.usb_present    = usb_seen;
    s.polling_active = |armed;
    return s;
  endfunction

  // Random voltage aimed at the interesting spots: rails, thresholds,
  // around delta from the last sample, around the level, a uniform pick, or a drift.
  function automatic logic [VB-1:0] pick_mv(input logic [VB-1:0] prev,
                                            input logic [VB-1:0] off,
                                            input logic [VB-1:0] on);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = MV_MAX;
      2:       v = int'($urandom_range(0, MV_MAX));
      3:       v = int'(off) + int'($urandom_range(0, 4)) - 2;
      4:       v = int'(on) + int'($urandom_range(0, 4)) - 2;
      5:       v = int'(prev) + int'(th_delta) + int'($urandom_range(0, 2)) - 1;
      6:       v = int'(prev) - int'(th_delta) - int'($urandom_range(0, 2)) + 1;
      7:       v = int'(th_level) + int'($urandom_range(0, 2)) - 1;
      default: v = int'(prev) + int'($urandom_range(0, 600)) - 300;
    endcase
    if (v < 0) v = 0;
    if (v > MV_MAX) v = MV_MAX;
    return VB'(v);
  endfunction

  // One input beat. Holds tvalid across back-to-back beats; an idle burst
  // drops it first. The expectation is queued at the accepting edge.
  task automatic send(input cmd_t c, input logic typed, input status_t want);
    status_t         predicted;
    logic [IN_W-1:0] beat;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    beat                 = '0;
    beat[1:0]            = c.opcode;
    beat[DC_LSB +: VB]   = c.dc_mv;
    beat[USB_LSB +: VB]  = c.usb_mv;
    beat[EN_BIT]         = c.arm_enable;
    beat[RISE_BIT]       = c.arm_rising;
    in_tdata            <= beat;
    in_tvalid           <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = predict_status(c);
    pending_status.push_back(typed ? want : predicted);
  endtask

  // Idle point: stream stopped, every result back, pipe flushed.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all six registers in list order, optionally hitting the two
  // unmapped indexes as well (the model ignores those).
  task automatic program_regs(input logic [VB-1:0] vals [6], input bit spare);
    for (int i = 0; i < 6; i++) begin
      cfg_wen   <= 1'b1;
      cfg_addr  <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (REG_ORDER[i])
        CFG_DC_OFF:     th_dc_off  = vals[i];
        CFG_DC_ON:      th_dc_on   = vals[i];
        CFG_USB_OFF:    th_usb_off = vals[i];
        CFG_USB_ON:     th_usb_on  = vals[i];
        CFG_EDGE_DELTA: th_delta   = vals[i];
        CFG_LEVEL:      th_level   = vals[i];
        default: ;
      endcase
    end
    if (spare) begin
      cfg_addr  <= CFG_SPARE_A;
      cfg_wdata <= VB'($urandom);
      @(posedge clk);
      cfg_addr  <= CFG_SPARE_B;
      cfg_wdata <= VB'($urandom);
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_beat(input logic [OUT_TDATA_BITS-1:0] d);
    status_t want;
    status_t seen;
    seen.dc_present     = d[OUT_DC_BIT];
    seen.usb_present    = d[OUT_USB_BIT];
    seen.usb_event      = usb_evt_t'(d[OUT_EVT_LSB +: 2]);
    seen.trigger        = trig_t'(d[OUT_TRIG_LSB +: 2]);
    seen.polling_active = d[OUT_POLL_BIT];
    if (pending_status.size() == 0) begin
      $display("%0t: result beat %h arrived with nothing expected", $time, d);
      mismatches++;
    end else begin
      want = pending_status.pop_front();
      if (seen.dc_present !== want.dc_present) begin
        $display("%0t: dc_present expected %0b got %0b",
                 $time, want.dc_present, seen.dc_present);
        mismatches++;
      end
      if (seen.usb_present !== want.usb_present) begin
        $display("%0t: usb_present expected %0b got %0b",
                 $time, want.usb_present, seen.usb_present);
        mismatches++;
      end
      if (seen.usb_event !== want.usb_event) begin
        $display("%0t: usb_event expected %0d got %0d",
                 $time, want.usb_event, seen.usb_event);
        mismatches++;
      end
      if (seen.trigger !== want.trigger) begin
        $display("%0t: trigger expected %0d got %0d",
                 $time, want.trigger, seen.trigger);
        mismatches++;
      end
      if (seen.polling_active !== want.polling_active) begin
        $display("%0t: polling_active expected %0b got %0b",
                 $time, want.polling_active, seen.polling_active);
        mismatches++;
      end
    end
  endtask

  // Result side: check on handshake, then pick next cycle's tready.
  // Stalls come as random bursts of tready low, except in the calm tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_beat(out_tdata);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a beat on either stream ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [VB-1:0] cfg_set [6];
    cmd_t          c;
    int            r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass under reset thresholds
    for (int i = 0; i < DIR_ROWS; i++)
      send(DIR_TAB[i].cmd, DIR_TAB[i].typed, DIR_TAB[i].want);

    for (int phase = 1; phase <= PHASES; phase++) begin
      wait_drained();
      // order: dc_off, dc_on, usb_off, usb_on, delta, level
      case (phase)
        1: begin
          foreach (cfg_set[k]) cfg_set[k] = '0;
        end
        2: begin
          foreach (cfg_set[k]) cfg_set[k] = VB'(MV_MAX);
        end
        3: begin
          // set thresholds below clear thresholds
          cfg_set[0] = VB'($urandom_range(3000, 9000));
          cfg_set[1] = VB'($urandom_range(0, 2999));
          cfg_set[2] = VB'($urandom_range(3000, 9000));
          cfg_set[3] = VB'($urandom_range(0, 2999));
          cfg_set[4] = VB'($urandom_range(0, 2000));
          cfg_set[5] = VB'($urandom_range(0, 9000));
        end
        PHASES: begin
          // back to defaults for the stall-free tail
          cfg_set[0] = VB'(DC_OFF_RESET);
          cfg_set[1] = VB'(DC_ON_RESET);
          cfg_set[2] = VB'(USB_OFF_RESET);
          cfg_set[3] = VB'(USB_ON_RESET);
          cfg_set[4] = VB'(EDGE_DELTA_RESET);
          cfg_set[5] = VB'(LEVEL_RESET);
          calm_tail  = 1'b1;
        end
        default: begin
          cfg_set[0] = VB'($urandom_range(0, 8000));
          cfg_set[1] = cfg_set[0] + VB'($urandom_range(0, 8000));
          cfg_set[2] = VB'($urandom_range(0, 8000));
          cfg_set[3] = cfg_set[2] + VB'($urandom_range(0, 8000));
          cfg_set[4] = VB'($urandom_range(0, 3000));
          cfg_set[5] = VB'($urandom_range(0, 12000));
        end
      endcase
      program_regs(cfg_set, phase == 1 || phase == 4);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // random arm bits on every beat, random voltages on arm beats:
        // the block must ignore whatever it does not use
        c.arm_enable = $urandom_range(0, 3) != 0;
        c.arm_rising = 1'($urandom_range(0, 1));
        c.dc_mv      = VB'($urandom);
        c.usb_mv     = VB'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          c.opcode = OP_ARM_DC;
        end else if (r < 16) begin
          c.opcode = OP_ARM_USB;
        end else if (r < 19) begin
          c.opcode = OP_SPARE;
        end else if (r < 25) begin
          // both rails dead: disarm path unless something triggers
          c.opcode = OP_TICK;
          c.dc_mv  = '0;
          c.usb_mv = '0;
        end else begin
          c.opcode = OP_TICK;
          c.dc_mv  = pick_mv(prev_dc, th_dc_off, th_dc_on);
          c.usb_mv = pick_mv(prev_usb, th_usb_off, th_usb_on);
        end
        send(c, 1'b0, NO_STATUS);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> dual_supply_voltage_monitor_core.f
+incdir+design
design/dsvm_pkg.sv
design/dual_supply_voltage_monitor_core.sv
design/dsvm_checker.sv
tb/tb_dual_supply_voltage_monitor_core.sv
